// ----- rtl/frame_filter_subscription_table_top_defines.svh -----
// assertion macros for the checker file of the filter table
// expects clk and rst in the scope where a macro is used
`ifndef FRAME_FILTER_SUBSCRIPTION_TABLE_TOP_DEFINES_SVH
`define FRAME_FILTER_SUBSCRIPTION_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define FFST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ffst_pkg.sv -----
// shared types, codes and helpers of the frame filter subscription table
// no dependencies
package ffst_pkg;

  localparam int SLOTS_DEFAULT = 8;
  localparam int MASK_SLOTS    = 8;   // slots visible in the match mask

  localparam logic [1:0] OP_OBSERVE     = 2'd0;
  localparam logic [1:0] OP_SUBSCRIBE   = 2'd1;
  localparam logic [1:0] OP_UNSUBSCRIBE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_FILTER = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  localparam logic [3:0] MAX_MATCH_LEN = 4'd8;

  // one stored filter
  typedef struct packed {
    logic [63:0] data_mask;
    logic [63:0] data;
    logic [3:0]  length;
    logic [1:0]  direction;
    logic [28:0] id_mask;
    logic [28:0] frame_id;
  } filt_t;

  localparam int FILT_W = $bits(filt_t);

  // observed frame as seen by the compare unit
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  length;
    logic [1:0]  direction;
    logic [28:0] frame_id;
  } frame_t;

  // mask covering the leading len bytes
  function automatic logic [63:0] lead_mask(input logic [3:0] len);
    logic [63:0] m;
    if (len >= MAX_MATCH_LEN) begin
      m = '1;
    end else begin
      m = (64'd1 << {len[2:0], 3'b000}) - 64'd1;
    end
    return m;
  endfunction

endpackage

// ----- rtl/ffst_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
module ffst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ffst_match.sv -----
// filter compare unit, one stored filter against one frame per cycle
// depends on ffst_pkg
module ffst_match import ffst_pkg::*; (
  input  frame_t frm,
  input  filt_t  flt,
  output logic   hit
);

  logic dir_ok;
  logic id_ok;
  logic len_ok;
  logic data_ok;

  always_comb begin
    dir_ok  = |(frm.direction & flt.direction);
    id_ok   = ((frm.frame_id ^ flt.frame_id) & flt.id_mask) == 29'd0;
    len_ok  = frm.length >= flt.length;
    data_ok = ((frm.data ^ flt.data) & flt.data_mask & lead_mask(flt.length)) == 64'd0;
    // a zero match length ignores frame length and data
    hit = dir_ok && id_ok && ((flt.length == 4'd0) || (len_ok && data_ok));
  end

endmodule

// ----- rtl/frame_filter_subscription_table_top.sv -----
// top level of the frame filter subscription table: sequencer, slot state
// depends on ffst_pkg, ffst_ram, ffst_match
//
// channel   dir  tuser          tdata
// s_axis    in   operation      direction, frame_id, id_mask, length, data,
//                               data_mask, handle
// m_axis    out  status         handle_out, match_mask, active_count
//
// observe walks the first min(SLOTS,8) slots of the filter memory one slot per
// cycle, through the single memory read port and the compare unit.
// subscribe probes one slot per cycle for the lowest free one.
// unsubscribe checks the handle in S_UNSUB; other operations go to S_DONE.
// s_axis_tready is high only between items, from the cycle after the result
// is loaded; a result that cannot load waits while the output register is held.
// synchronous reset clears all slots and generations; no clearing pass.
module frame_filter_subscription_table_top import ffst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // direction[1:0], frame_id[30:2], id_mask[59:31], length[63:60],
  // data[127:64], data_mask[191:128], handle[207:192]
  input  logic [207:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // handle_out[15:0], match_mask[23:16], active_count[27:24], zero[31:28]
  output logic [31:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW     = $clog2(SLOTS + 1);
  localparam int SCAN_N = (SLOTS < MASK_SLOTS) ? SLOTS : MASK_SLOTS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OBS,
    S_SUB,
    S_UNSUB,
    S_DONE
  } state_t;

  state_t      state;
  logic [CW-1:0] cnt;
  logic          rd_valid;
  logic [CW-1:0] rd_slot;
  logic [CW-1:0] count;
  logic [SLOTS-1:0] slot_used;
  logic [7:0]    slot_gen [SLOTS];

  // captured item
  filt_t       item_flt;
  logic [15:0] item_hnd;

  logic [1:0]  res_status;
  logic [15:0] res_handle;
  logic [7:0]  res_match;

  logic [1:0]  in_op;
  filt_t       in_flt;
  frame_t      frm;
  filt_t       ram_rdata;
  logic        ram_we;
  logic        ram_re;
  logic        hit;
  logic [IW-1:0] ci;
  logic [IW-1:0] uidx;
  logic [IW-1:0] gen_idx;
  logic [7:0]  gen_rd;
  logic [7:0]  hnd_low;
  logic [7:0]  hnd_gen;
  logic        low_ok;
  logic [3:0]  active;

  assign in_op              = s_axis_tuser;
  assign in_flt.direction   = s_axis_tdata[1:0];
  assign in_flt.frame_id    = s_axis_tdata[30:2];
  assign in_flt.id_mask     = s_axis_tdata[59:31];
  assign in_flt.length      = s_axis_tdata[63:60];
  assign in_flt.data        = s_axis_tdata[127:64];
  assign in_flt.data_mask   = s_axis_tdata[191:128];

  assign s_axis_tready = (state == S_IDLE);

  assign frm.data      = item_flt.data;
  assign frm.length    = item_flt.length;
  assign frm.direction = item_flt.direction;
  assign frm.frame_id  = item_flt.frame_id;

  assign ci      = cnt[IW-1:0];
  assign hnd_low = item_hnd[7:0];
  assign hnd_gen = item_hnd[15:8];
  assign low_ok  = (hnd_low != 8'd0) && (int'(hnd_low) <= SLOTS);
  assign uidx    = IW'(hnd_low - 8'd1);
  assign gen_idx = (state == S_UNSUB) ? uidx : ci;
  assign gen_rd  = slot_gen[gen_idx];

  assign ram_we = (state == S_SUB) && !slot_used[ci];
  assign ram_re = (state == S_OBS) && (cnt < CW'(SCAN_N));

  assign active = (int'(count) > 15) ? 4'd15 : 4'(count);

  ffst_ram #(
    .WIDTH (FILT_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ci),
    .wdata (item_flt),
    .re    (ram_re),
    .raddr (ci),
    .rdata (ram_rdata)
  );

  ffst_match u_match (
    .frm (frm),
    .flt (ram_rdata),
    .hit (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      count         <= '0;
      rd_valid      <= 1'b0;
      slot_used     <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_gen[i] <= 8'd0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            item_flt   <= in_flt;
            item_hnd   <= s_axis_tdata[207:192];
            cnt        <= '0;
            rd_valid   <= 1'b0;
            res_status <= ST_OK;
            res_handle <= 16'd0;
            res_match  <= 8'd0;
            case (in_op)
              OP_OBSERVE: begin
                state <= S_OBS;
              end
              OP_SUBSCRIBE: begin
                if (in_flt.length > MAX_MATCH_LEN || in_flt.direction == 2'd0) begin
                  res_status <= ST_BAD_FILTER;
                  state      <= S_DONE;
                end else begin
                  state <= S_SUB;
                end
              end
              OP_UNSUBSCRIBE: begin
                state <= S_UNSUB;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_OBS: begin
          // read data arrives in the cycle after its address
          if (rd_valid && slot_used[rd_slot[IW-1:0]] && hit) begin
            res_match <= res_match | (8'd1 << rd_slot);
          end
          if (rd_valid && rd_slot == CW'(SCAN_N - 1)) begin
            state <= S_DONE;
          end
          rd_valid <= ram_re;
          rd_slot  <= cnt;
          if (ram_re) begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SUB: begin
          if (!slot_used[ci]) begin
            slot_used[ci] <= 1'b1;
            count         <= count + 1'b1;
            res_handle    <= {gen_rd, 8'(cnt) + 8'd1};
            state         <= S_DONE;
          end else if (cnt == CW'(SLOTS - 1)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_UNSUB: begin
          if (low_ok && slot_used[uidx] && gen_rd == hnd_gen) begin
            slot_used[uidx] <= 1'b0;
            slot_gen[uidx]  <= gen_rd + 8'd1;
            count           <= count - 1'b1;
          end else begin
            res_status <= ST_BAD_HANDLE;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= {4'd0, active, res_match, res_handle};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ffst_checker.sv -----
// port-level checks of the frame filter subscription table, bound to the top
// depends on ffst_pkg and frame_filter_subscription_table_top_defines.svh
`include "frame_filter_subscription_table_top_defines.svh"

module ffst_checker import ffst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // one item at a time: the sequencer leaves idle after a transaction
  `FFST_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

  `FFST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // failed operations never hand out a handle
  `FFST_ASSERT_NOW(a_fail_no_handle, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata[15:0] == 16'd0, "handle on failed operation")

  `FFST_ASSERT_NOW(a_count_range, m_axis_tvalid, int'(m_axis_tdata[27:24]) <= SLOTS, "active count above slot count")

endmodule

bind frame_filter_subscription_table_top ffst_checker #(.SLOTS(SLOTS)) u_ffst_checker (.*);
